>>> rtl/frsb_pkg.sv
// ----------------------------------------------------------------------------
// frsb_pkg: shared types and constants of the four-rotor byte generator
// command codes, state layout and the control word passed to the core
// ----------------------------------------------------------------------------
package frsb_pkg;

	// state vector layout
	localparam int unsigned VEC_LEN   = 17;
	localparam int unsigned IDX_W     = $clog2(VEC_LEN);
	localparam logic [IDX_W-1:0] OFF_TWO   = IDX_W'(0);
	localparam logic [IDX_W-1:0] OFF_THREE = IDX_W'(2);
	localparam logic [IDX_W-1:0] OFF_FIVE  = IDX_W'(5);
	localparam logic [IDX_W-1:0] OFF_SEVEN = IDX_W'(10);

	// burst length limit
	localparam int unsigned MAX_BURST = 64;
	localparam int unsigned CNT_W     = 7;

	// command codes carried on tuser
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_SET_POS = 2'd1,
		CMD_GEN     = 2'd2
	} frsb_cmd_t;

	// control word from the burst controller to the generator core
	typedef struct packed {
		logic        load;
		logic        set_pos;
		logic        step;
		logic [4:0]  seed_index;
		logic [7:0]  seed_value;
		logic [11:0] start_position;
	} frsb_ctrl_t;

endpackage

>>> rtl/frsb_gen.sv
// ----------------------------------------------------------------------------
// frsb_gen: rotor state bank and byte generator
// holds the 17 state bytes and the phase counters, forms the output byte
// and folds it back into the state on every step
// ----------------------------------------------------------------------------
module frsb_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  frsb_pkg::frsb_ctrl_t ctrl,
	output logic [7:0]         random_byte
);
	import frsb_pkg::*;

	logic [7:0] state_q [VEC_LEN];
	logic       p2_q;
	logic [1:0] p3_q;
	logic [2:0] p5_q;
	logic [2:0] p7_q;
	logic [IDX_W-1:0] p17_q;

	logic [7:0] sum;
	logic [7:0] rot;

	// residues by digit folding: 4 = 1 mod 3, 16 = 1 mod 5, 8 = 1 mod 7,
	// 256 = 1 and 16 = -1 mod 17
	function automatic logic [1:0] mod3(input logic [11:0] x);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6]) + 5'(x[9:8])
			+ 5'(x[11:10]);
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
	endfunction

	function automatic logic [2:0] mod5(input logic [11:0] x);
		logic [5:0] s;
		logic [4:0] t;
		logic [4:0] u;
		s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]);
		t = 5'(s[3:0]) + 5'(s[5:4]);
		u = 5'(t[3:0]) + 5'(t[4]);
		if (u >= 5'd15)
			return 3'(u - 5'd15);
		else if (u >= 5'd10)
			return 3'(u - 5'd10);
		else if (u >= 5'd5)
			return 3'(u - 5'd5);
		else
			return u[2:0];
	endfunction

	function automatic logic [2:0] mod7(input logic [11:0] x);
		logic [4:0] s;
		logic [3:0] t;
		s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]);
		t = 4'(s[2:0]) + 4'(s[4:3]);
		return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
	endfunction

	function automatic logic [IDX_W-1:0] mod17(input logic [11:0] x);
		logic [8:0] s;
		logic [8:0] y;
		logic [5:0] r;
		s = 9'(x[7:0]) + 9'(x[11:8]);
		y = 9'(s[7:0]) + 9'(s[8]);
		r = 6'(y[3:0]) + 6'(VEC_LEN) - 6'(y[8:4]);
		return (r >= 6'(VEC_LEN)) ? IDX_W'(r - 6'(VEC_LEN)) : IDX_W'(r);
	endfunction

	// one tap from each rotor, sum mod 256
	assign sum = state_q[OFF_TWO + IDX_W'(p2_q)] + state_q[OFF_THREE + IDX_W'(p3_q)]
		+ state_q[OFF_FIVE + IDX_W'(p5_q)] + state_q[OFF_SEVEN + IDX_W'(p7_q)];
	assign rot = {sum[6:0], sum[7]};
	assign random_byte = sum;

	// each state byte updates itself, no shared read port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < VEC_LEN; j++) state_q[j] <= 8'h00;
		end else begin
			for (int j = 0; j < VEC_LEN; j++) begin
				if (ctrl.load && (ctrl.seed_index == 5'(j)))
					state_q[j] <= ctrl.seed_value;
				else if (ctrl.step && (p17_q == IDX_W'(j)))
					state_q[j] <= state_q[j] + rot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p2_q  <= 1'b0;
			p3_q  <= '0;
			p5_q  <= '0;
			p7_q  <= '0;
			p17_q <= '0;
		end else if (ctrl.set_pos) begin
			p2_q  <= ctrl.start_position[0];
			p3_q  <= mod3(ctrl.start_position);
			p5_q  <= mod5(ctrl.start_position);
			p7_q  <= mod7(ctrl.start_position);
			p17_q <= mod17(ctrl.start_position);
		end else if (ctrl.step) begin
			p2_q  <= ~p2_q;
			p3_q  <= (p3_q == 2'd2) ? 2'd0 : p3_q + 2'd1;
			p5_q  <= (p5_q == 3'd4) ? 3'd0 : p5_q + 3'd1;
			p7_q  <= (p7_q == 3'd6) ? 3'd0 : p7_q + 3'd1;
			p17_q <= (p17_q == IDX_W'(VEC_LEN - 1)) ? '0 : p17_q + IDX_W'(1);
		end
	end

endmodule

>>> rtl/four_rotor_sum_byte_prng.sv
// ----------------------------------------------------------------------------
// four_rotor_sum_byte_prng: four-rotor summing byte generator
// streaming command in, pseudo-random byte stream out
// ----------------------------------------------------------------------------
// Each input word carries a command on tuser: load one of the 17 state bytes,
// set the position, or generate a burst of 1 to 64 bytes (larger counts are
// clipped to 64, a count of zero gives nothing). Load and set-position words
// retire as soon as they are held and produce no output. A generate word stays
// in the command register until its last byte is formed, so the block delivers
// one byte per cycle while the output side keeps tready high; the next command
// is taken in the cycle that retires the last byte. The throughput figure is
// set by the state update: each byte folds back into the state before the next
// one is formed. tlast marks the final byte of each burst. A generate word is
// held in the command register, its first byte then in the output register.
// ----------------------------------------------------------------------------
module four_rotor_sum_byte_prng (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // seed_index[4:0], seed_value[12:5],
	                                   // start_position[24:13], byte_count[31:25]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // random_byte[7:0]
	output logic        m_axis_tlast
);
	import frsb_pkg::*;

	// command register
	logic             in_valid_q;
	frsb_cmd_t        cmd_q;
	logic [4:0]       seed_index_q;
	logic [7:0]       seed_value_q;
	logic [11:0]      start_pos_q;
	logic [CNT_W-1:0] remaining_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic             in_accept;
	logic             out_free;
	logic             is_gen;
	logic             step;
	logic             done;
	logic [CNT_W-1:0] count_sat;
	logic [7:0]       gen_byte;
	frsb_ctrl_t       ctrl;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	// output slot can take a new word this cycle
	assign out_free  = !out_valid_q || m_axis_tready;
	assign is_gen    = (cmd_q == CMD_GEN);

	// one byte leaves the core whenever a burst is pending and the slot is free
	assign step = in_valid_q && is_gen && (remaining_q != '0) && out_free;

	// the held word retires this cycle
	always_comb begin
		done = 1'b0;
		if (in_valid_q) begin
			unique case (cmd_q)
				CMD_GEN: done = (remaining_q == '0) || ((remaining_q == CNT_W'(1)) && out_free);
				default: done = 1'b1;
			endcase
		end
	end

	assign s_axis_tready = !in_valid_q || done;

	// clip burst length
	assign count_sat = (s_axis_tdata[31:25] > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
		: s_axis_tdata[31:25];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			remaining_q <= '0;
		end else if (in_accept) begin
			in_valid_q  <= 1'b1;
			remaining_q <= count_sat;
		end else begin
			if (done)
				in_valid_q <= 1'b0;
			if (step)
				remaining_q <= remaining_q - CNT_W'(1);
		end
	end

	// payload of the command register
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q        <= frsb_cmd_t'(s_axis_tuser);
			seed_index_q <= s_axis_tdata[4:0];
			seed_value_q <= s_axis_tdata[12:5];
			start_pos_q  <= s_axis_tdata[24:13];
		end
	end

	always_comb begin
		ctrl.load           = in_valid_q && (cmd_q == CMD_LOAD);
		ctrl.set_pos        = in_valid_q && (cmd_q == CMD_SET_POS);
		ctrl.step           = step;
		ctrl.seed_index     = seed_index_q;
		ctrl.seed_value     = seed_value_q;
		ctrl.start_position = start_pos_q;
	end

	frsb_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.random_byte (gen_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= gen_byte;
			out_last_q <= (remaining_q == CNT_W'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// non-generate words and empty bursts never hold up the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_q && (!is_gen || (remaining_q == '0))) |-> s_axis_tready)
		else $error("command register stalled on a word that makes no output");

	// every step lands in the output register with the right last flag
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (m_axis_tvalid && (m_axis_tlast == ($past(remaining_q) == CNT_W'(1)))))
		else $error("generated byte not presented with correct last flag");

	// burst counter stays within the clipped range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_q |-> (remaining_q <= CNT_W'(MAX_BURST)))
		else $error("burst counter out of range");

	// a burst word is never dropped before its last byte leaves
	a_burst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_q && is_gen && (remaining_q > CNT_W'(1))) |-> !s_axis_tready)
		else $error("input accepted while burst still pending");

endmodule

>>> tb/four_rotor_sum_byte_prng_test.sv
// ----------------------------------------------------------------------------
// four_rotor_sum_byte_prng_test: self-checking bench for the rotor byte generator
// command words go in on the slave stream and every generated byte is checked
// against a bit-exact software copy of the four rotors and the position
// counters. A short directed part covers seeding, position wrap, burst limits
// and ignored commands. Random traffic then runs under four idle/stall mixes.
// ----------------------------------------------------------------------------
module four_rotor_sum_byte_prng_test;
	import frsb_pkg::*;

	// tuser code with no command behind it, the block must drop it
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned POS_PERIOD = 3570;
	localparam int unsigned DRAIN_CYCLES = 20;

	// one generated byte as it should appear on the master side
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} rotor_byte_t;

	// software copy of the generator plus the bytes still owed by the block
	class rotor_sum_tracker;
		logic [7:0]  state_bytes [VEC_LEN];
		logic        phase_two;
		logic [1:0]  phase_three;
		logic [2:0]  phase_five;
		logic [2:0]  phase_seven;
		logic [4:0]  phase_seventeen;
		rotor_byte_t awaited_bytes [$];
		int          mismatch_count;

		function new();
			foreach (state_bytes[k])
				state_bytes[k] = 8'd0;
			phase_two       = 1'b0;
			phase_three     = 2'd0;
			phase_five      = 3'd0;
			phase_seven     = 3'd0;
			phase_seventeen = 5'd0;
			mismatch_count  = 0;
		endfunction

		// sum of the four rotor taps, then fold the rotated sum back into the vector
		function logic [7:0] next_rotor_sum();
			logic [7:0] sum;
			logic [7:0] rotated;
			sum = state_bytes[int'(OFF_TWO) + int'(phase_two)]
			    + state_bytes[int'(OFF_THREE) + int'(phase_three)]
			    + state_bytes[int'(OFF_FIVE) + int'(phase_five)]
			    + state_bytes[int'(OFF_SEVEN) + int'(phase_seven)];
			rotated = {sum[6:0], sum[7]};
			state_bytes[phase_seventeen] = state_bytes[phase_seventeen] + rotated;
			phase_two       = ~phase_two;
			phase_three     = (phase_three == 2'd2) ? 2'd0 : phase_three + 2'd1;
			phase_five      = (phase_five == 3'd4) ? 3'd0 : phase_five + 3'd1;
			phase_seven     = (phase_seven == 3'd6) ? 3'd0 : phase_seven + 3'd1;
			phase_seventeen = (phase_seventeen == 5'(VEC_LEN - 1)) ? 5'd0
			                : phase_seventeen + 5'd1;
			return sum;
		endfunction

		// apply one accepted command word
		function void note_command(logic [1:0] cmd_bits, logic [31:0] data);
			frsb_cmd_t   cmd;
			logic [4:0]  seed_index;
			logic [7:0]  seed_value;
			logic [11:0] start_position;
			logic [6:0]  byte_count;
			int unsigned burst;
			rotor_byte_t item;
			cmd            = frsb_cmd_t'(cmd_bits);
			seed_index     = data[4:0];
			seed_value     = data[12:5];
			start_position = data[24:13];
			byte_count     = data[31:25];
			case (cmd)
				CMD_LOAD: begin
					// indexes past the vector are dropped
					if (seed_index < VEC_LEN)
						state_bytes[seed_index] = seed_value;
				end
				CMD_SET_POS: begin
					// each counter takes the position modulo its own length
					phase_two       = 1'(start_position % 2);
					phase_three     = 2'(start_position % 3);
					phase_five      = 3'(start_position % 5);
					phase_seven     = 3'(start_position % 7);
					phase_seventeen = 5'(start_position % VEC_LEN);
				end
				CMD_GEN: begin
					// counts above the burst limit are clipped, zero gives nothing
					burst = (byte_count > MAX_BURST) ? MAX_BURST : byte_count;
					for (int k = 0; k < burst; k++) begin
						item.value = next_rotor_sum();
						item.last  = (k == burst - 1);
						awaited_bytes.push_back(item);
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatch_count++;
		endtask

		// compare one accepted output word with the oldest owed byte
		task check_byte(logic [7:0] value, logic last);
			rotor_byte_t want;
			if (awaited_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %02h arrived with none owed", value));
			end else begin
				want = awaited_bytes.pop_front();
				if (value !== want.value)
					report_mismatch($sformatf("byte %02h, wanted %02h", value, want.value));
				if (last !== want.last)
					report_mismatch($sformatf("tlast %b, wanted %b", last, want.last));
			end
		endtask
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = 32'd0;  // seed_index[4:0], seed_value[12:5],
	                                     // start_position[24:13], byte_count[31:25]
	logic [1:0]  s_axis_tuser  = 2'd0;   // command[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;           // random_byte[7:0]
	logic        m_axis_tlast;

	// percentages of cycles the sender idles and the receiver stalls
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	rotor_sum_tracker tracker = new();

	four_rotor_sum_byte_prng i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// both monitors sample the values that held just before the edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tracker.note_command(s_axis_tuser, s_axis_tdata);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_byte(m_axis_tdata, m_axis_tlast);
	end

	function automatic logic [31:0] pack_word(logic [4:0] seed_index, logic [7:0] seed_value,
	                                          logic [11:0] start_position,
	                                          logic [6:0] byte_count);
		return {byte_count, start_position, seed_value, seed_index};
	endfunction

	// present one word, with random idle cycles ahead of it, and hold until taken
	task automatic send_word(logic [1:0] cmd, logic [31:0] data);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// one random command; effective tells whether it does anything at all
	task automatic send_random_command(output bit effective);
		logic [1:0]  cmd;
		logic [4:0]  seed_index;
		logic [11:0] start_position;
		logic [6:0]  byte_count;
		int unsigned pick;
		int unsigned count_kind;
		seed_index = 5'($urandom_range(VEC_LEN - 1));
		if ($urandom_range(9) == 0)
			seed_index = 5'($urandom_range(31));
		start_position = 12'($urandom_range(POS_PERIOD - 1));
		if ($urandom_range(7) == 0)
			start_position = 12'($urandom_range(4095));
		// mostly short bursts, some up to the burst limit, a few zero or oversized
		count_kind = $urandom_range(19);
		if (count_kind == 0)
			byte_count = 7'd0;
		else if (count_kind == 1)
			byte_count = 7'($urandom_range(127, MAX_BURST + 1));
		else if (count_kind < 5)
			byte_count = 7'($urandom_range(MAX_BURST, 1));
		else
			byte_count = 7'($urandom_range(12, 1));
		pick = $urandom_range(99);
		if (pick < 30)
			cmd = CMD_LOAD;
		else if (pick < 45)
			cmd = CMD_SET_POS;
		else if (pick < 92)
			cmd = CMD_GEN;
		else
			cmd = CMD_UNUSED;
		effective = (cmd == CMD_LOAD && seed_index < VEC_LEN) || (cmd == CMD_SET_POS)
		         || (cmd == CMD_GEN && byte_count != 0);
		send_word(cmd, pack_word(seed_index, 8'($urandom_range(255)), start_position,
		                         byte_count));
	endtask

	task automatic run_random_phase(int unsigned idle, int unsigned stall, int unsigned items);
		int unsigned done;
		bit          effective;
		idle_pct  = idle;
		stall_pct = stall;
		done      = 0;
		while (done < items) begin
			send_random_command(effective);
			if (effective)
				done++;
		end
	endtask

	initial begin
		// reset held from the start, released once
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero state first, then seed a few taps and push the edges
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'd3));
		send_word(CMD_LOAD, pack_word(5'd0, 8'hff, 12'd0, 7'd0));
		send_word(CMD_LOAD, pack_word(5'd16, 8'h80, 12'd0, 7'd0));
		send_word(CMD_LOAD, pack_word(5'd31, 8'h55, 12'hfff, 7'h7f));  // index past vector
		send_word(CMD_LOAD, pack_word(5'd17, 8'haa, 12'd0, 7'd0));      // index past vector
		send_word(CMD_LOAD, pack_word(5'd10, 8'h01, 12'd0, 7'd0));
		send_word(CMD_LOAD, pack_word(5'd5, 8'h7f, 12'd0, 7'd0));
		send_word(CMD_LOAD, pack_word(5'd2, 8'hc3, 12'd0, 7'd0));
		send_word(CMD_SET_POS, pack_word(5'd0, 8'd0, 12'd0, 7'd0));
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'(MAX_BURST)));
		// last position of the period, then wrap through zero
		send_word(CMD_SET_POS, pack_word(5'd0, 8'd0, 12'(POS_PERIOD - 1), 7'd0));
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'd2));
		// positions at and past the period reduce modulo each rotor length
		send_word(CMD_SET_POS, pack_word(5'd0, 8'd0, 12'hfff, 7'd0));
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'h7f));          // clipped burst
		send_word(CMD_GEN, pack_word(5'h1f, 8'hff, 12'hfff, 7'd0));       // empty burst
		send_word(CMD_UNUSED, pack_word(5'h1f, 8'hff, 12'hfff, 7'h7f));   // dropped
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'(MAX_BURST + 1)));
		send_word(CMD_SET_POS, pack_word(5'd0, 8'd0, 12'(POS_PERIOD), 7'd0));
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'd1));
		send_word(CMD_LOAD, pack_word(5'd16, 8'd0, 12'd0, 7'd0));
		send_word(CMD_GEN, pack_word(5'd0, 8'd0, 12'd0, 7'd5));

		// random traffic under each idle/stall mix
		run_random_phase(0, 0, 60);
		run_random_phase(62, 0, 60);
		run_random_phase(0, 62, 60);
		run_random_phase(36, 36, 60);
		s_axis_tvalid <= 1'b0;

		// let the monitor note the last word, then drain what is still owed
		@(posedge clk);
		while (tracker.awaited_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if ((tracker.mismatch_count == 0) && (tracker.awaited_bytes.size() == 0)) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// run time cap, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
rtl/frsb_pkg.sv
rtl/frsb_gen.sv
rtl/four_rotor_sum_byte_prng.sv
tb/four_rotor_sum_byte_prng_test.sv
